FILE: rtl/bct_pkg.sv
// Shared constants, types and command struct for the Bezier tessellation block.
// No dependencies.
package bct_pkg;

    localparam int MAX_SEGMENTS = 63;
    localparam int FRAC_BITS    = 16;
    localparam int PT_W         = 32;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int DIFF_W       = PT_W + 1;
    localparam int H_W          = PT_W + 6;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int PROD_W       = H_W + T_W;
    localparam int IN_W         = 8 * PT_W;
    localparam int OUT_FIELDS_W = SEG_W + 2 * PT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // register index, taken from paddr above the byte offset
    localparam logic REG_SEGMENTS = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_COEF,
        S_MUL,
        S_ADD,
        S_PUT
    } state_t;

    typedef enum logic [1:0] {
        COEF_B,
        COEF_C,
        COEF_D
    } coef_sel_t;

    typedef enum logic [1:0] {
        OUT_P0,
        OUT_P3,
        OUT_CURVE
    } out_sel_t;

    typedef struct packed {
        logic             capture;
        logic             diff;
        logic             coef;
        logic             h_load;
        logic             t_adv;
        logic             mul;
        logic             add;
        coef_sel_t        coef_sel;
        logic             out_load;
        out_sel_t         out_sel;
        logic [SEG_W-1:0] index;
        logic             last;
    } cmd_t;

endpackage

FILE: rtl/bezier_curve_tessellation.sv
// Cubic Bezier curve tessellation: top level with register port and assertions.
// Depends on bct_pkg, bct_ctrl and bct_datapath.
//
// Usage:
//   Set the segment count n through the register port (byte address 0) while idle.
//   Each input transaction carries four control points p0..p3 (x, y, Q16.16).
//   For n > 0 the block emits n+1 output transactions, point index 0..n, with
//   tlast on point n; point 0 is p0 and point n is p3. For n = 0 an input
//   transaction is consumed and nothing is emitted.
//   Steps per item: capture, coefficient setup, a direct output load for each
//   end point, and for each interior point three multiply and add steps on one
//   multiplier per coordinate, then the output load.
//   s_tready is high only while no item is being worked on; the last point
//   may still be waiting in the output register when the next item is taken.
//   When the receiver stalls, the output register holds its transaction and
//   the controller waits before loading the next point.
//   Reset (aresetn low, synchronous) clears the segment count to zero, empties
//   the output register and returns the controller to idle.
module bezier_curve_tessellation
    import bct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_index, curve_x, curve_y, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    logic [SEG_W-1:0] seg_reg;
    logic             reg_sel;
    cmd_t             cmd;

    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_SEGMENTS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W-SEG_W){1'b0}}, seg_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            seg_reg <= pwdata[SEG_W-1:0];
        end
    end

    bct_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .segments_i (seg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd)
    );

    bct_datapath u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .segments_i (seg_reg),
        .s_tdata    (s_tdata),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[SEG_W-1:0] == seg_reg)
        else $error("last point index differs from segment count");

    a_inner_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[SEG_W-1:0] < seg_reg)
        else $error("non-last point index out of range");

    a_zero_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && seg_reg == '0 |=> s_tready)
        else $error("item with zero segments started work");

endmodule

FILE: rtl/bct_lane.sv
// One coordinate lane: control points, Horner coefficients, multiply and saturate.
// Depends on bct_pkg.
module bct_lane
    import bct_pkg::*;
(
    input  logic            aclk,
    input  cmd_t            cmd,
    input  logic [PT_W-1:0] p0_i,
    input  logic [PT_W-1:0] p1_i,
    input  logic [PT_W-1:0] p2_i,
    input  logic [PT_W-1:0] p3_i,
    input  logic [FRAC_BITS-1:0] t_i,
    output logic [PT_W-1:0] value_o
);

    logic [PT_W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic [DIFF_W-1:0] d1_reg, d2_reg, d3_reg;
    logic [H_W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic [H_W-1:0]    h_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [H_W-1:0]           e1, e2, e3, dd;
    logic [H_W-1:0]           coef;
    logic signed [PROD_W-1:0] shifted;
    logic [H_W-PT_W:0]        h_top;
    logic [PT_W-1:0]          sat;

    assign e1 = {{(H_W-DIFF_W){d1_reg[DIFF_W-1]}}, d1_reg};
    assign e2 = {{(H_W-DIFF_W){d2_reg[DIFF_W-1]}}, d2_reg};
    assign e3 = {{(H_W-DIFF_W){d3_reg[DIFF_W-1]}}, d3_reg};
    assign dd = e2 - e1;

    always_comb begin
        case (cmd.coef_sel)
            COEF_B:  coef = b_reg;
            COEF_C:  coef = c_reg;
            default: coef = d_reg;
        endcase
    end

    assign shifted = $signed(prod_reg) >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            p0_reg <= p0_i;
            p1_reg <= p1_i;
            p2_reg <= p2_i;
            p3_reg <= p3_i;
        end
        if (cmd.diff) begin
            d1_reg <= {p1_reg[PT_W-1], p1_reg} - {p0_reg[PT_W-1], p0_reg};
            d2_reg <= {p2_reg[PT_W-1], p2_reg} - {p1_reg[PT_W-1], p1_reg};
            d3_reg <= {p3_reg[PT_W-1], p3_reg} - {p2_reg[PT_W-1], p2_reg};
        end
        if (cmd.coef) begin
            a_reg <= e3 - e2 - dd;
            b_reg <= dd + {dd[H_W-2:0], 1'b0};
            c_reg <= e1 + {e1[H_W-2:0], 1'b0};
            d_reg <= {{(H_W-PT_W){p0_reg[PT_W-1]}}, p0_reg};
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'($signed(h_reg) * $signed({1'b0, t_i}));
        end
        if (cmd.add) begin
            h_reg <= shifted[H_W-1:0] + coef;
        end else if (cmd.h_load) begin
            h_reg <= a_reg;
        end
    end

    // saturate to the signed output range
    assign h_top = h_reg[H_W-1:PT_W-1];

    always_comb begin
        if (h_top == '0 || h_top == '1) begin
            sat = h_reg[PT_W-1:0];
        end else if (h_reg[H_W-1]) begin
            sat = {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(PT_W-1){1'b1}}};
        end
    end

    always_comb begin
        case (cmd.out_sel)
            OUT_P0:  value_o = p0_reg;
            OUT_P3:  value_o = p3_reg;
            default: value_o = sat;
        endcase
    end

endmodule

FILE: rtl/bct_datapath.sv
// Datapath: parameter step table, t accumulator, x and y lanes, output register.
// Depends on bct_pkg and bct_lane.
module bct_datapath
    import bct_pkg::*;
(
    input  logic             aclk,
    input  cmd_t             cmd,
    input  logic [SEG_W-1:0] segments_i,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    logic [T_W-1:0]   step_tab [MAX_SEGMENTS+1];
    logic [T_W-1:0]   step_reg, t_reg;
    logic [PT_W-1:0]  x_val, y_val;
    logic [PT_W-1:0]  x_reg, y_reg;
    logic [SEG_W-1:0] index_reg;
    logic             last_reg;

    assign step_tab[0] = '0;
    for (genvar g = 1; g <= MAX_SEGMENTS; g++) begin : g_step
        localparam int STEP = (1 << FRAC_BITS) / g;
        assign step_tab[g] = T_W'(STEP);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            step_reg <= step_tab[segments_i];
            t_reg    <= step_tab[segments_i];
        end else if (cmd.t_adv) begin
            t_reg <= t_reg + step_reg;
        end
        if (cmd.out_load) begin
            index_reg <= cmd.index;
            last_reg  <= cmd.last;
            x_reg     <= x_val;
            y_reg     <= y_val;
        end
    end

    bct_lane u_lane_x (
        .aclk    (aclk),
        .cmd     (cmd),
        .p0_i    (s_tdata[0*PT_W +: PT_W]),
        .p1_i    (s_tdata[2*PT_W +: PT_W]),
        .p2_i    (s_tdata[4*PT_W +: PT_W]),
        .p3_i    (s_tdata[6*PT_W +: PT_W]),
        .t_i     (t_reg[FRAC_BITS-1:0]),
        .value_o (x_val)
    );

    bct_lane u_lane_y (
        .aclk    (aclk),
        .cmd     (cmd),
        .p0_i    (s_tdata[1*PT_W +: PT_W]),
        .p1_i    (s_tdata[3*PT_W +: PT_W]),
        .p2_i    (s_tdata[5*PT_W +: PT_W]),
        .p3_i    (s_tdata[7*PT_W +: PT_W]),
        .t_i     (t_reg[FRAC_BITS-1:0]),
        .value_o (y_val)
    );

    assign m_tdata = {{(OUT_W-OUT_FIELDS_W){1'b0}}, y_reg, x_reg, index_reg};
    assign m_tlast = last_reg;

endmodule

FILE: rtl/bct_ctrl.sv
// Controller: sequences capture, coefficient setup, Horner steps and output loads.
// Depends on bct_pkg.
module bct_ctrl
    import bct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [SEG_W-1:0] segments_i,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cmd_t             cmd
);

    state_t           state_reg, state_next;
    logic [SEG_W-1:0] k_reg, k_next;
    logic [SEG_W-1:0] n_reg, n_next;
    coef_sel_t        j_reg, j_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic             is_last;
    logic             out_free;
    logic [SEG_W-1:0] k_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            n_reg        <= '0;
            j_reg        <= COEF_B;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            j_reg        <= j_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign is_last  = (k_reg == n_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign k_inc    = k_reg + SEG_W'(1);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        j_next     = j_reg;

        cmd          = '0;
        cmd.coef_sel = j_reg;
        cmd.index    = k_reg;
        cmd.last     = is_last;
        if (k_reg == '0) begin
            cmd.out_sel = OUT_P0;
        end else if (is_last) begin
            cmd.out_sel = OUT_P3;
        end else begin
            cmd.out_sel = OUT_CURVE;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (segments_i != '0) begin
                        n_next     = segments_i;
                        k_next     = '0;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_COEF;
            end
            S_COEF: begin
                cmd.coef   = 1'b1;
                state_next = S_PUT;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add = 1'b1;
                case (j_reg)
                    COEF_B: begin
                        j_next     = COEF_C;
                        state_next = S_MUL;
                    end
                    COEF_C: begin
                        j_next     = COEF_D;
                        state_next = S_MUL;
                    end
                    default: begin
                        state_next = S_PUT;
                    end
                endcase
            end
            S_PUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.h_load   = 1'b1;
                    cmd.t_adv    = (k_reg != '0);
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next = k_inc;
                        j_next = COEF_B;
                        if (k_inc == n_reg) begin
                            state_next = S_PUT;
                        end else begin
                            state_next = S_MUL;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

endmodule
